[design/pgr_pkg.sv]
package pgr_pkg;

  localparam int RankW    = 31;
  localparam int DegW     = 16;
  localparam int NodeCntW = 7;
  localparam int CfgW     = 31;
  localparam int PortIdxW = 6;
  localparam int CmdW     = 2;
  localparam int CfgIdxW  = 2;

  localparam logic [RankW-1:0] RankMax = {RankW{1'b1}};

  typedef enum logic [CmdW-1:0] {
    CMD_ADD   = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NODE_COUNT = 2'd0,
    REG_DAMPING    = 2'd1,
    REG_TOLERANCE  = 2'd2,
    REG_MAX_ITER   = 2'd3
  } cfg_reg_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CLEAR, OP_EDGE_RD, OP_EDGE_WR, OP_SETUP, OP_BASE_LD,
    OP_WDANG_LD, OP_INIT_RD, OP_INIT_DIV, OP_INIT_WR, OP_ITER, OP_TERM_RD,
    OP_TERM_MUL, OP_TERM_WR, OP_SUM_RD, OP_SUM_ACC, OP_NEW_MUL, OP_NEW_WR,
    OP_NORM_MUL, OP_NORM_ACC, OP_NEXT, OP_FINISH, OP_OUT_RD, OP_OUT_EMIT
  } op_e;

  typedef enum logic [21:0] {
    S_IDLE      = 22'h000001,
    S_EDGE_RD   = 22'h000002,
    S_EDGE_WR   = 22'h000004,
    S_DIV_BASE  = 22'h000008,
    S_DIV_WDANG = 22'h000010,
    S_INIT_RD   = 22'h000020,
    S_INIT_DIV  = 22'h000040,
    S_INIT_WAIT = 22'h000080,
    S_ITER      = 22'h000100,
    S_TERM_RD   = 22'h000200,
    S_TERM_MUL  = 22'h000400,
    S_TERM_WR   = 22'h000800,
    S_SUM_RD    = 22'h001000,
    S_SUM_ACC   = 22'h002000,
    S_NEW_MUL   = 22'h004000,
    S_NEW_WR    = 22'h008000,
    S_NORM_MUL  = 22'h010000,
    S_NORM_ACC  = 22'h020000,
    S_CHECK     = 22'h040000,
    S_OUT_RD    = 22'h080000,
    S_OUT_EMIT  = 22'h100000,
    S_SPARE     = 22'h200000
  } state_e;

  typedef struct packed {
    op_e op;
  } ctrl_t;

  typedef struct packed {
    logic div_busy;
    logic i_last;
    logic j_last;
    logic conv;
    logic at_cap;
  } stat_t;

endpackage

[design/pgr_div.sv]
module pgr_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pgr_pkg::RankW-1:0]  dividend_i,
  input  logic [pgr_pkg::DegW-1:0]   divisor_i,
  output logic                       busy_o,
  output logic [pgr_pkg::RankW-1:0]  quot_o
);

  localparam int W    = pgr_pkg::RankW;
  localparam int DW   = pgr_pkg::DegW;
  localparam int CntW = $clog2(W + 1);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    quo_q;
  logic [DW-1:0]   rem_q;
  logic [DW-1:0]   dvs_q;
  logic [DW:0]     rem_sh;
  logic [DW:0]     diff;
  logic            ge;

  assign rem_sh = {rem_q, quo_q[W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[W-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

[design/pgr_ctrl.sv]
module pgr_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic [pgr_pkg::CmdW-1:0]  cmd_i,
  input  pgr_pkg::stat_t            stat_i,
  output pgr_pkg::ctrl_t            ctrl_o,
  output logic                      busy
);

  pgr_pkg::state_e state_q, state_d;
  pgr_pkg::op_e    op;

  always_comb begin
    op      = pgr_pkg::OP_NONE;
    state_d = state_q;
    case (state_q)
      pgr_pkg::S_IDLE: begin
        if (start) begin
          case (cmd_i)
            pgr_pkg::CMD_ADD: begin
              op      = pgr_pkg::OP_LOAD;
              state_d = pgr_pkg::S_EDGE_RD;
            end
            pgr_pkg::CMD_RUN: begin
              op      = pgr_pkg::OP_SETUP;
              state_d = pgr_pkg::S_DIV_BASE;
            end
            pgr_pkg::CMD_CLEAR: begin
              op = pgr_pkg::OP_CLEAR;
            end
            default: begin
              op = pgr_pkg::OP_NONE;
            end
          endcase
        end
      end
      pgr_pkg::S_EDGE_RD: begin
        op      = pgr_pkg::OP_EDGE_RD;
        state_d = pgr_pkg::S_EDGE_WR;
      end
      pgr_pkg::S_EDGE_WR: begin
        op      = pgr_pkg::OP_EDGE_WR;
        state_d = pgr_pkg::S_IDLE;
      end
      pgr_pkg::S_DIV_BASE: begin
        if (!stat_i.div_busy) begin
          op      = pgr_pkg::OP_BASE_LD;
          state_d = pgr_pkg::S_DIV_WDANG;
        end
      end
      pgr_pkg::S_DIV_WDANG: begin
        if (!stat_i.div_busy) begin
          op      = pgr_pkg::OP_WDANG_LD;
          state_d = pgr_pkg::S_INIT_RD;
        end
      end
      pgr_pkg::S_INIT_RD: begin
        op      = pgr_pkg::OP_INIT_RD;
        state_d = pgr_pkg::S_INIT_DIV;
      end
      pgr_pkg::S_INIT_DIV: begin
        op      = pgr_pkg::OP_INIT_DIV;
        state_d = pgr_pkg::S_INIT_WAIT;
      end
      pgr_pkg::S_INIT_WAIT: begin
        if (!stat_i.div_busy) begin
          op      = pgr_pkg::OP_INIT_WR;
          state_d = stat_i.i_last ? pgr_pkg::S_ITER : pgr_pkg::S_INIT_RD;
        end
      end
      pgr_pkg::S_ITER: begin
        op      = pgr_pkg::OP_ITER;
        state_d = pgr_pkg::S_TERM_RD;
      end
      pgr_pkg::S_TERM_RD: begin
        op      = pgr_pkg::OP_TERM_RD;
        state_d = pgr_pkg::S_TERM_MUL;
      end
      pgr_pkg::S_TERM_MUL: begin
        op      = pgr_pkg::OP_TERM_MUL;
        state_d = pgr_pkg::S_TERM_WR;
      end
      pgr_pkg::S_TERM_WR: begin
        op      = pgr_pkg::OP_TERM_WR;
        state_d = stat_i.i_last ? pgr_pkg::S_SUM_RD : pgr_pkg::S_TERM_RD;
      end
      pgr_pkg::S_SUM_RD: begin
        op      = pgr_pkg::OP_SUM_RD;
        state_d = pgr_pkg::S_SUM_ACC;
      end
      pgr_pkg::S_SUM_ACC: begin
        op      = pgr_pkg::OP_SUM_ACC;
        state_d = stat_i.i_last ? pgr_pkg::S_NEW_MUL : pgr_pkg::S_SUM_RD;
      end
      pgr_pkg::S_NEW_MUL: begin
        op      = pgr_pkg::OP_NEW_MUL;
        state_d = pgr_pkg::S_NEW_WR;
      end
      pgr_pkg::S_NEW_WR: begin
        op      = pgr_pkg::OP_NEW_WR;
        state_d = pgr_pkg::S_NORM_MUL;
      end
      pgr_pkg::S_NORM_MUL: begin
        op      = pgr_pkg::OP_NORM_MUL;
        state_d = pgr_pkg::S_NORM_ACC;
      end
      pgr_pkg::S_NORM_ACC: begin
        op      = pgr_pkg::OP_NORM_ACC;
        state_d = stat_i.j_last ? pgr_pkg::S_CHECK : pgr_pkg::S_SUM_RD;
      end
      pgr_pkg::S_CHECK: begin
        if (stat_i.conv || stat_i.at_cap) begin
          op      = pgr_pkg::OP_FINISH;
          state_d = pgr_pkg::S_OUT_RD;
        end else begin
          op      = pgr_pkg::OP_NEXT;
          state_d = pgr_pkg::S_TERM_RD;
        end
      end
      pgr_pkg::S_OUT_RD: begin
        op      = pgr_pkg::OP_OUT_RD;
        state_d = pgr_pkg::S_OUT_EMIT;
      end
      pgr_pkg::S_OUT_EMIT: begin
        op      = pgr_pkg::OP_OUT_EMIT;
        state_d = stat_i.i_last ? pgr_pkg::S_IDLE : pgr_pkg::S_OUT_RD;
      end
      default: begin
        state_d = pgr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pgr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign ctrl_o.op = op;
  assign busy      = (state_q != pgr_pkg::S_IDLE);

endmodule

[design/pgr_dp.sv]
module pgr_dp #(
  parameter int MAX_NODES = 64,
  parameter int FRAC_BITS = 30
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pgr_pkg::ctrl_t                ctrl_i,
  output pgr_pkg::stat_t                stat_o,
  input  logic                          cfg_we_i,
  input  logic [pgr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pgr_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic [pgr_pkg::PortIdxW-1:0]  src_node_i,
  input  logic [pgr_pkg::PortIdxW-1:0]  dst_node_i,
  output logic                          out_valid_o,
  output logic [pgr_pkg::PortIdxW-1:0]  node_index_o,
  output logic [pgr_pkg::RankW-1:0]     rank_value_o,
  output logic [pgr_pkg::DegW-1:0]      iteration_count_o,
  output logic                          capped_o,
  output logic                          last_o
);

  localparam int IW   = $clog2(MAX_NODES);
  localparam int NW   = IW + 1;
  localparam int RW   = pgr_pkg::RankW;
  localparam int DW   = pgr_pkg::DegW;
  localparam int ACCW = RW + IW + 1;
  localparam int PW   = 2 * RW;
  localparam logic [RW-1:0] One = RW'(1) << FRAC_BITS;

  logic [MAX_NODES-1:0] adj_mem  [MAX_NODES];
  logic [DW-1:0]        deg_mem  [MAX_NODES];
  logic [RW-1:0]        wrow_mem [MAX_NODES];
  logic [RW-1:0]        term_mem [MAX_NODES];
  logic [RW-1:0]        rank_mem [2*MAX_NODES];

  logic [MAX_NODES-1:0]        vld_q;
  logic [pgr_pkg::NodeCntW-1:0] cfg_n_q;
  logic [RW-1:0]               cfg_d_q;
  logic [RW-1:0]               cfg_tol_q;
  logic [DW-1:0]               cfg_cap_q;

  logic [NW-1:0]   n_q;
  logic [RW-1:0]   d_q;
  logic [DW-1:0]   cap_q;
  logic [IW-1:0]   i_q;
  logic [IW-1:0]   j_q;
  logic            pb_q;
  logic [DW-1:0]   it_q;
  logic            capped_q;
  logic            out_valid_q;

  logic [pgr_pkg::PortIdxW-1:0] src_q;
  logic [pgr_pkg::PortIdxW-1:0] dst_q;
  logic                         edge_ok_q;
  logic [MAX_NODES-1:0]         adj_rd_q;
  logic [DW-1:0]                deg_rd_q;
  logic                         rvld_q;
  logic [RW-1:0]                wrow_rd_q;
  logic [RW-1:0]                rank_rd_q;
  logic [RW-1:0]                term_rd_q;
  logic [RW-1:0]                base_q;
  logic [RW-1:0]                wdang_q;
  logic [PW-1:0]                mul_q;
  logic [PW-1:0]                tol2_q;
  logic [ACCW-1:0]              acc_q;
  logic [RW-1:0]                diff_q;
  logic [63:0]                  norm_q;
  logic [IW-1:0]                out_idx_q;
  logic [RW-1:0]                out_rank_q;
  logic [DW-1:0]                out_it_q;
  logic                         out_capped_q;
  logic                         out_last_q;

  logic [NW-1:0]   n_eff;
  logic [RW-1:0]   d_eff;
  logic [IW-1:0]   src_idx;
  logic [IW-1:0]   rd_idx;
  logic [DW-1:0]   deg_eff;
  logic            i_last;
  logic            j_last;
  logic            div_start;
  logic [RW-1:0]   div_dividend;
  logic [DW-1:0]   div_divisor;
  logic            div_busy;
  logic [RW-1:0]   div_quot;
  logic [RW-1:0]   mul_a;
  logic [RW-1:0]   mul_b;
  logic            mul_en;
  logic [RW-1:0]   s_sat;
  logic [RW:0]     pnew_w;
  logic [RW-1:0]   pnew;
  logic [64:0]     norm_sum;
  logic            sel_bit;
  logic [MAX_NODES-1:0] row_new;
  logic [DW-1:0]   deg_new;
  pgr_pkg::op_e    op;

  assign op = ctrl_i.op;

  always_comb begin
    if (cfg_n_q == '0) begin
      n_eff = NW'(1);
    end else if (cfg_n_q > pgr_pkg::NodeCntW'(MAX_NODES)) begin
      n_eff = NW'(MAX_NODES);
    end else begin
      n_eff = NW'(cfg_n_q);
    end
  end

  assign d_eff   = (cfg_d_q > One) ? One : cfg_d_q;
  assign src_idx = src_q[IW-1:0];
  assign rd_idx  = (op == pgr_pkg::OP_EDGE_RD) ? src_idx : i_q;
  assign deg_eff = rvld_q ? deg_rd_q : '0;
  assign i_last  = ({1'b0, i_q} == n_q - 1'b1);
  assign j_last  = ({1'b0, j_q} == n_q - 1'b1);

  assign div_start = (op == pgr_pkg::OP_SETUP) || (op == pgr_pkg::OP_BASE_LD) ||
                     (op == pgr_pkg::OP_INIT_DIV);

  always_comb begin
    div_dividend = One;
    div_divisor  = DW'(n_q);
    case (op)
      pgr_pkg::OP_SETUP: begin
        div_dividend = One - d_eff;
        div_divisor  = DW'(n_eff);
      end
      pgr_pkg::OP_INIT_DIV: begin
        div_divisor = (deg_eff == '0) ? DW'(n_q) : deg_eff;
      end
      default: begin
        div_divisor = DW'(n_q);
      end
    endcase
  end

  pgr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  assign s_sat = (acc_q > ACCW'(pgr_pkg::RankMax)) ? pgr_pkg::RankMax : acc_q[RW-1:0];

  always_comb begin
    mul_en = 1'b1;
    mul_a  = cfg_tol_q;
    mul_b  = cfg_tol_q;
    case (op)
      pgr_pkg::OP_SETUP: begin
        mul_a = cfg_tol_q;
        mul_b = cfg_tol_q;
      end
      pgr_pkg::OP_TERM_MUL: begin
        mul_a = wrow_rd_q;
        mul_b = rank_rd_q;
      end
      pgr_pkg::OP_NEW_MUL: begin
        mul_a = d_q;
        mul_b = s_sat;
      end
      pgr_pkg::OP_NORM_MUL: begin
        mul_a = diff_q;
        mul_b = diff_q;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign pnew_w   = {1'b0, base_q} + (RW + 1)'(mul_q >> FRAC_BITS);
  assign pnew     = pnew_w[RW] ? pgr_pkg::RankMax : pnew_w[RW-1:0];
  assign norm_sum = {1'b0, norm_q} + 65'(mul_q);
  assign sel_bit  = !rvld_q || (deg_rd_q == '0) || adj_rd_q[j_q];
  assign row_new  = (rvld_q ? adj_rd_q : '0) | (MAX_NODES'(1) << dst_q[IW-1:0]);
  assign deg_new  = (deg_eff == '1) ? deg_eff : deg_eff + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      cfg_n_q     <= pgr_pkg::NodeCntW'(64);
      cfg_d_q     <= RW'(912680550);
      cfg_tol_q   <= RW'(1074);
      cfg_cap_q   <= DW'(1000);
      i_q         <= '0;
      j_q         <= '0;
      pb_q        <= 1'b0;
      it_q        <= '0;
      capped_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (op == pgr_pkg::OP_OUT_EMIT);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pgr_pkg::REG_NODE_COUNT: cfg_n_q   <= cfg_wdata_i[pgr_pkg::NodeCntW-1:0];
          pgr_pkg::REG_DAMPING:    cfg_d_q   <= cfg_wdata_i[RW-1:0];
          pgr_pkg::REG_TOLERANCE:  cfg_tol_q <= cfg_wdata_i[RW-1:0];
          pgr_pkg::REG_MAX_ITER:   cfg_cap_q <= cfg_wdata_i[DW-1:0];
          default: begin
            cfg_cap_q <= cfg_cap_q;
          end
        endcase
      end
      case (op)
        pgr_pkg::OP_CLEAR: begin
          vld_q <= '0;
        end
        pgr_pkg::OP_EDGE_WR: begin
          if (edge_ok_q) begin
            vld_q[src_idx] <= 1'b1;
          end
        end
        pgr_pkg::OP_SETUP: begin
          it_q <= '0;
          pb_q <= 1'b0;
        end
        pgr_pkg::OP_WDANG_LD: begin
          i_q <= '0;
        end
        pgr_pkg::OP_INIT_WR, pgr_pkg::OP_TERM_WR, pgr_pkg::OP_SUM_ACC,
        pgr_pkg::OP_OUT_EMIT: begin
          i_q <= i_last ? '0 : i_q + 1'b1;
        end
        pgr_pkg::OP_ITER: begin
          it_q <= it_q + 1'b1;
          i_q  <= '0;
          j_q  <= '0;
        end
        pgr_pkg::OP_NEXT: begin
          it_q <= it_q + 1'b1;
          i_q  <= '0;
          j_q  <= '0;
          pb_q <= !pb_q;
        end
        pgr_pkg::OP_NORM_ACC: begin
          j_q <= j_last ? '0 : j_q + 1'b1;
        end
        pgr_pkg::OP_FINISH: begin
          capped_q <= !stat_o.conv;
          pb_q     <= !pb_q;
          i_q      <= '0;
        end
        default: begin
          i_q <= i_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      mul_q <= mul_a * mul_b;
    end
    case (op)
      pgr_pkg::OP_LOAD: begin
        src_q     <= src_node_i;
        dst_q     <= dst_node_i;
        edge_ok_q <= ({1'b0, src_node_i} < pgr_pkg::NodeCntW'(MAX_NODES)) &&
                     ({1'b0, dst_node_i} < pgr_pkg::NodeCntW'(MAX_NODES));
      end
      pgr_pkg::OP_EDGE_RD, pgr_pkg::OP_INIT_RD, pgr_pkg::OP_SUM_RD: begin
        adj_rd_q  <= adj_mem[rd_idx];
        deg_rd_q  <= deg_mem[rd_idx];
        rvld_q    <= vld_q[rd_idx];
        term_rd_q <= term_mem[rd_idx];
      end
      pgr_pkg::OP_EDGE_WR: begin
        if (edge_ok_q) begin
          adj_mem[src_idx] <= row_new;
          deg_mem[src_idx] <= deg_new;
        end
      end
      pgr_pkg::OP_SETUP: begin
        n_q   <= n_eff;
        d_q   <= d_eff;
        cap_q <= (cfg_cap_q == '0) ? DW'(1) : cfg_cap_q;
      end
      pgr_pkg::OP_BASE_LD: begin
        base_q <= div_quot;
        tol2_q <= mul_q;
      end
      pgr_pkg::OP_WDANG_LD: begin
        wdang_q <= div_quot;
      end
      pgr_pkg::OP_INIT_WR: begin
        wrow_mem[i_q]          <= div_quot;
        rank_mem[{1'b0, i_q}]  <= wdang_q;
      end
      pgr_pkg::OP_ITER, pgr_pkg::OP_NEXT: begin
        acc_q  <= '0;
        norm_q <= '0;
      end
      pgr_pkg::OP_TERM_RD: begin
        wrow_rd_q <= wrow_mem[i_q];
        rank_rd_q <= rank_mem[{pb_q, i_q}];
      end
      pgr_pkg::OP_TERM_WR: begin
        term_mem[i_q] <= RW'(mul_q >> FRAC_BITS);
      end
      pgr_pkg::OP_SUM_ACC: begin
        if (sel_bit) begin
          acc_q <= acc_q + ACCW'(term_rd_q);
        end
      end
      pgr_pkg::OP_NEW_MUL, pgr_pkg::OP_OUT_RD: begin
        rank_rd_q <= rank_mem[{pb_q, (op == pgr_pkg::OP_OUT_RD) ? i_q : j_q}];
      end
      pgr_pkg::OP_NEW_WR: begin
        rank_mem[{!pb_q, j_q}] <= pnew;
        diff_q <= (pnew >= rank_rd_q) ? pnew - rank_rd_q : rank_rd_q - pnew;
      end
      pgr_pkg::OP_NORM_ACC: begin
        norm_q <= norm_sum[64] ? '1 : norm_sum[63:0];
        acc_q  <= '0;
      end
      pgr_pkg::OP_OUT_EMIT: begin
        out_idx_q    <= i_q;
        out_rank_q   <= rank_rd_q;
        out_it_q     <= it_q;
        out_capped_q <= capped_q;
        out_last_q   <= i_last;
      end
      default: begin
        src_q <= src_q;
      end
    endcase
  end

  assign stat_o.div_busy = div_busy;
  assign stat_o.i_last   = i_last;
  assign stat_o.j_last   = j_last;
  assign stat_o.conv     = norm_q < 64'(tol2_q);
  assign stat_o.at_cap   = it_q >= cap_q;

  assign out_valid_o       = out_valid_q;
  assign node_index_o      = pgr_pkg::PortIdxW'(out_idx_q);
  assign rank_value_o      = out_rank_q;
  assign iteration_count_o = out_it_q;
  assign capped_o          = out_capped_q;
  assign last_o            = out_last_q;

endmodule

[design/pagerank_power_iteration_top.sv]
// Add edge reads the source row and then writes it back; clear graph and an unused command
// finish in the idle state. A run does its setup divisions on one shared 31-step divider,
// then iterates until converged or capped, then delivers the ranks one node at a time.
// Throughput is set by the single multiplier and one read port per memory.
// Reset is asynchronous and active low; it empties the graph and loads defaults.
// Results are strobed for one cycle each and cannot be stalled by the receiver.
module pagerank_power_iteration_top #(
  parameter int MAX_NODES = 64,
  parameter int FRAC_BITS = 30
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [pgr_pkg::CmdW-1:0]      cmd_i,
  input  logic [pgr_pkg::PortIdxW-1:0]  src_node_i,
  input  logic [pgr_pkg::PortIdxW-1:0]  dst_node_i,
  input  logic                          cfg_we_i,
  input  logic [pgr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pgr_pkg::CfgW-1:0]      cfg_wdata_i,
  output logic                          out_valid_o,
  output logic [pgr_pkg::PortIdxW-1:0]  node_index_o,
  output logic [pgr_pkg::RankW-1:0]     rank_value_o,
  output logic [pgr_pkg::DegW-1:0]      iteration_count_o,
  output logic                          capped_o,
  output logic                          last_o
);

  pgr_pkg::ctrl_t ctrl;
  pgr_pkg::stat_t stat;

  pgr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy   (busy)
  );

  pgr_dp #(
    .MAX_NODES (MAX_NODES),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .stat_o            (stat),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .src_node_i        (src_node_i),
    .dst_node_i        (dst_node_i),
    .out_valid_o       (out_valid_o),
    .node_index_o      (node_index_o),
    .rank_value_o      (rank_value_o),
    .iteration_count_o (iteration_count_o),
    .capped_o          (capped_o),
    .last_o            (last_o)
  );

`ifndef SYNTHESIS
  a_run_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == pgr_pkg::CMD_RUN) |=> busy)
    else $error("Accepted run did not make the block busy.");

  a_more_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |=> (!out_valid_o && busy))
    else $error("Result stream ended before the final node.");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> !busy)
    else $error("Block still busy on the final result.");
`endif

endmodule

[sim/pagerank_checker.sv]
`timescale 1ns / 1ps

module pagerank_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic                         busy,
  input  logic [pgr_pkg::CmdW-1:0]     cmd_i,
  input  logic [pgr_pkg::PortIdxW-1:0] src_node_i,
  input  logic [pgr_pkg::PortIdxW-1:0] dst_node_i,
  input  logic                         cfg_we_i,
  input  logic [pgr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pgr_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                         out_valid_o,
  input  logic [pgr_pkg::PortIdxW-1:0] node_index_o,
  input  logic [pgr_pkg::RankW-1:0]    rank_value_o,
  input  logic [pgr_pkg::DegW-1:0]     iteration_count_o,
  input  logic                         capped_o,
  input  logic                         last_o,
  output int                           errors_o,
  output int                           pending_o
);

  localparam longint unsigned One = 64'd1 << 30;

  typedef struct packed {
    logic [pgr_pkg::PortIdxW-1:0] node;
    logic [pgr_pkg::RankW-1:0]    rank;
    logic [pgr_pkg::DegW-1:0]     iters;
    logic                         capped;
    logic                         last;
  } rank_result_t;

  rank_result_t expected_ranks[$];

  logic [6:0]  node_count;
  logic [30:0] damping;
  logic [30:0] tolerance;
  logic [15:0] max_iter;
  logic [63:0] adjacency[64];
  logic [15:0] out_degree[64];

  function automatic longint unsigned sat31(longint unsigned v);
    return (v > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : v;
  endfunction

  task automatic predict_ranking();
    longint unsigned n, d, cap, tol2, base, wdang, s, norm, diff, sq;
    longint unsigned wrow[64];
    longint unsigned cur[64];
    longint unsigned prev[64];
    int unsigned it;
    logic was_capped;
    rank_result_t r;
    n = node_count;
    d = damping;
    cap = max_iter;
    tol2 = longint'(tolerance) * longint'(tolerance);
    it = 0;
    was_capped = 1'b0;
    if (n == 0) n = 1;
    if (n > 64) n = 64;
    if (d > One) d = One;
    if (cap == 0) cap = 1;
    base = (One - d) / n;
    wdang = One / n;
    for (int i = 0; i < n; i++) begin
      wrow[i] = (out_degree[i] != 0) ? One / out_degree[i] : wdang;
      cur[i] = wdang;
    end
    forever begin
      norm = 0;
      it++;
      for (int i = 0; i < n; i++) prev[i] = cur[i];
      for (int j = 0; j < n; j++) begin
        s = 0;
        for (int i = 0; i < n; i++)
          if (out_degree[i] == 0 || adjacency[i][j]) s += (wrow[i] * prev[i]) >> 30;
        s = sat31(s);
        cur[j] = sat31(base + ((d * s) >> 30));
      end
      for (int i = 0; i < n; i++) begin
        diff = (cur[i] > prev[i]) ? cur[i] - prev[i] : prev[i] - cur[i];
        sq = diff * diff;
        norm = (norm > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : norm + sq;
      end
      if (norm < tol2) break;
      if (it >= cap) begin
        was_capped = 1'b1;
        break;
      end
    end
    for (int i = 0; i < n; i++) begin
      r.node = i[pgr_pkg::PortIdxW-1:0];
      r.rank = cur[i][pgr_pkg::RankW-1:0];
      r.iters = it[pgr_pkg::DegW-1:0];
      r.capped = was_capped;
      r.last = (i == n - 1);
      expected_ranks.push_back(r);
    end
  endtask

  assign pending_o = expected_ranks.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rank_result_t got;
    rank_result_t want;
    if (!rst_ni) begin
      node_count <= 7'd64;
      damping <= 31'd912680550;
      tolerance <= 31'd1074;
      max_iter <= 16'd1000;
      for (int i = 0; i < 64; i++) begin
        adjacency[i] = '0;
        out_degree[i] = '0;
      end
      errors_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (pgr_pkg::cfg_reg_e'(cfg_idx_i))
          pgr_pkg::REG_NODE_COUNT: node_count <= cfg_wdata_i[6:0];
          pgr_pkg::REG_DAMPING:    damping <= cfg_wdata_i;
          pgr_pkg::REG_TOLERANCE:  tolerance <= cfg_wdata_i;
          pgr_pkg::REG_MAX_ITER:   max_iter <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (cmd_i)
          pgr_pkg::CMD_ADD: begin
            adjacency[src_node_i][dst_node_i] = 1'b1;
            if (out_degree[src_node_i] != 16'hFFFF) out_degree[src_node_i]++;
          end
          pgr_pkg::CMD_RUN: predict_ranking();
          pgr_pkg::CMD_CLEAR: begin
            for (int i = 0; i < 64; i++) begin
              adjacency[i] = '0;
              out_degree[i] = '0;
            end
          end
          default: ;
        endcase
      end
      if (out_valid_o) begin
        got = '{node_index_o, rank_value_o, iteration_count_o, capped_o, last_o};
        if (expected_ranks.size() == 0) begin
          if (errors_o < 10) $display("unexpected rank result %p", got);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_ranks.pop_front();
          if (got !== want) begin
            if (errors_o < 10) $display("rank mismatch: expected %p actual %p", want, got);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

[sim/tb_pagerank_power_iteration_top.sv]
`timescale 1ns / 1ps

module tb_pagerank_power_iteration_top;

  localparam logic [30:0] One = 31'h4000_0000;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [pgr_pkg::CmdW-1:0]     cmd_i = pgr_pkg::CMD_ADD;
  logic [pgr_pkg::PortIdxW-1:0] src_node_i = '0;
  logic [pgr_pkg::PortIdxW-1:0] dst_node_i = '0;
  logic                         cfg_we_i = 1'b0;
  logic [pgr_pkg::CfgIdxW-1:0]  cfg_idx_i = pgr_pkg::REG_NODE_COUNT;
  logic [pgr_pkg::CfgW-1:0]     cfg_wdata_i = '0;
  logic                         out_valid_o;
  logic [pgr_pkg::PortIdxW-1:0] node_index_o;
  logic [pgr_pkg::RankW-1:0]    rank_value_o;
  logic [pgr_pkg::DegW-1:0]     iteration_count_o;
  logic                         capped_o;
  logic                         last_o;
  int                           errors;
  int                           pending;
  bit                           idling = 1'b1;
  int unsigned                  nodes;

  always #5 clk_i = ~clk_i;

  pagerank_power_iteration_top dut (.*);

  pagerank_checker u_checker (.*, .errors_o(errors), .pending_o(pending));

  task automatic send_request(pgr_pkg::cmd_e c, int unsigned s, int unsigned d);
    if (idling && $urandom_range(99) < 20) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    src_node_i <= s[pgr_pkg::PortIdxW-1:0];
    dst_node_i <= d[pgr_pkg::PortIdxW-1:0];
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (busy || pending != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_config(int unsigned n, logic [30:0] d, logic [30:0] tol, int unsigned cap);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= pgr_pkg::REG_NODE_COUNT;
    cfg_wdata_i <= 31'(n);
    @(posedge clk_i);
    cfg_idx_i <= pgr_pkg::REG_DAMPING;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_idx_i <= pgr_pkg::REG_TOLERANCE;
    cfg_wdata_i <= tol;
    @(posedge clk_i);
    cfg_idx_i <= pgr_pkg::REG_MAX_ITER;
    cfg_wdata_i <= 31'(cap);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    nodes = (n == 0) ? 1 : n;
  endtask

  task automatic random_request();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 75) begin
      if ($urandom_range(99) < 80)
        send_request(pgr_pkg::CMD_ADD, $urandom_range(nodes - 1), $urandom_range(nodes - 1));
      else
        send_request(pgr_pkg::CMD_ADD, $urandom_range(63), $urandom_range(63));
    end else if (pick < 90) begin
      send_request(pgr_pkg::CMD_RUN, $urandom_range(63), $urandom_range(63));
    end else if (pick < 95) begin
      send_request(pgr_pkg::CMD_CLEAR, $urandom_range(63), $urandom_range(63));
    end else begin
      send_request(pgr_pkg::cmd_e'(2'd3), $urandom_range(63), $urandom_range(63));
    end
  endtask

  initial begin
    logic [30:0] tol;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_config(4, 31'd912680550, 31'd1074, 200);
    send_request(pgr_pkg::CMD_ADD, 0, 1);
    send_request(pgr_pkg::CMD_ADD, 1, 2);
    send_request(pgr_pkg::CMD_ADD, 2, 0);
    send_request(pgr_pkg::CMD_ADD, 0, 1);
    send_request(pgr_pkg::CMD_ADD, 2, 63);
    send_request(pgr_pkg::CMD_ADD, 63, 0);
    send_request(pgr_pkg::cmd_e'(2'd3), 63, 63);
    send_request(pgr_pkg::CMD_RUN, 0, 0);
    send_request(pgr_pkg::CMD_CLEAR, 0, 0);
    send_request(pgr_pkg::CMD_RUN, 0, 0);
    send_request(pgr_pkg::CMD_ADD, 3, 3);
    send_request(pgr_pkg::CMD_RUN, 0, 0);
    drain();
    write_config(0, One, 31'd0, 0);
    send_request(pgr_pkg::CMD_RUN, 0, 0);
    drain();
    write_config(127, 31'h7FFF_FFFF, 31'd0, 2);
    send_request(pgr_pkg::CMD_ADD, 63, 62);
    send_request(pgr_pkg::CMD_ADD, 5, 63);
    send_request(pgr_pkg::CMD_RUN, 0, 0);
    drain();
    write_config(64, 31'd0, One, 65535);
    send_request(pgr_pkg::CMD_RUN, 0, 0);
    drain();

    for (int p = 0; p < 10; p++) begin
      idling = !(p >= 3 && p <= 5);
      case ($urandom_range(3))
        0: tol = 31'd0;
        1: tol = 31'd1074;
        2: tol = 31'($urandom_range(100000));
        default: tol = 31'($urandom);
      endcase
      write_config(($urandom_range(9) == 0) ? $urandom_range(1, 16) : $urandom_range(2, 8),
                   ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(0, One)),
                   tol, $urandom_range(1, 30));
      repeat (28) random_request();
      send_request(pgr_pkg::CMD_RUN, $urandom_range(63), $urandom_range(63));
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("FAIL");
    $finish;
  end

endmodule

[filelist.f]
design/pgr_pkg.sv
design/pgr_div.sv
design/pgr_ctrl.sv
design/pgr_dp.sv
design/pagerank_power_iteration_top.sv
sim/pagerank_checker.sv
sim/tb_pagerank_power_iteration_top.sv
